// ===== design/assert_macros.svh =====
// Assertion helpers used by the interpolator top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication under reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/nddi_pkg.sv =====
// ============================================================================
// nddi_pkg: shared types, codes and saturating helpers
// Formats, request and result structs, and sign/magnitude helpers for the
// Newton divided-difference interpolator.
// ============================================================================
package nddi_pkg;

    localparam int MAX_NODES = 16;
    localparam int FRAC_BITS = 16;
    localparam int IFRAC     = 2 * FRAC_BITS;

    localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_NO_CONV   = 2'd1;
    localparam logic [1:0] ST_LOAD_OK   = 2'd2;
    localparam logic [1:0] ST_LOAD_REJ  = 2'd3;

    localparam int          CFG_IDX_W        = 1;
    localparam int          CFG_DATA_W       = 31;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'b1;
    localparam logic [30:0] TOLERANCE_RESET  = 31'd655;
    localparam logic [4:0]  NODE_COUNT_RESET = 5'd1;

    typedef struct packed {
        logic               command;
        logic [3:0]         node_index;
        logic signed [31:0] node_x;
        logic signed [31:0] node_y;
        logic signed [31:0] query_x;
    } req_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } node_t;

    typedef struct packed {
        logic               start;
        logic signed [63:0] num;
        logic signed [32:0] den;
    } div_req_t;

    typedef struct packed {
        logic               start;
        logic               wide;
        logic signed [63:0] a;
        logic signed [63:0] b;
    } mul_req_t;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        mag64 = v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] from_mag(input logic [63:0] mag, input logic neg);
        logic [63:0] m;
        m = mag[63] ? MAG_MAX : mag;
        from_mag = neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [63:0] clamp65(input logic signed [64:0] v);
        if (v > $signed({1'b0, MAG_MAX}))
            clamp65 = $signed(MAG_MAX);
        else if (v < -$signed({1'b0, MAG_MAX}))
            clamp65 = -$signed(MAG_MAX);
        else
            clamp65 = v[63:0];
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        sat_add = clamp65($signed({a[63], a}) + $signed({b[63], b}));
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        sat_sub = clamp65($signed({a[63], a}) - $signed({b[63], b}));
    endfunction

endpackage

// ===== design/nddi_div.sv =====
// ============================================================================
// nddi_div: serial fractional divider
// Restoring division, one quotient bit a cycle, giving (num << FRAC_BITS) / den
// truncated toward zero and saturated.
// ============================================================================
module nddi_div (
    input  logic                clk,
    input  logic                rst_n,
    input  nddi_pkg::div_req_t  req,
    output logic                done,
    output logic signed [63:0]  quo
);

    localparam int STEPS = 64 + nddi_pkg::FRAC_BITS;
    localparam int CW    = $clog2(STEPS);

    logic               busy_reg, busy_next;
    logic               fin_reg, fin_next;
    logic               done_reg, done_next;
    logic [63:0]        nm_reg, nm_next;
    logic [32:0]        dm_reg, dm_next;
    logic [32:0]        rem_reg, rem_next;
    logic [63:0]        q_reg, q_next;
    logic               ovf_reg, ovf_next;
    logic               neg_reg, neg_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic signed [63:0] quo_reg, quo_next;
    logic [33:0]        rem_sh;
    logic [33:0]        rem_diff;
    logic               ge;

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = fin_reg;
        done_next = 1'b0;
        nm_next   = nm_reg;
        dm_next   = dm_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_sh    = {rem_reg, nm_reg[63]};
        ge        = rem_sh >= {1'b0, dm_reg};
        rem_diff  = rem_sh - {1'b0, dm_reg};
        if (req.start)
        begin
            neg_next = req.num[63] ^ req.den[32];
            nm_next  = nddi_pkg::mag64(req.num);
            dm_next  = req.den[32] ? 33'(-req.den) : 33'(req.den);
            rem_next = '0;
            q_next   = '0;
            ovf_next = 1'b0;
            cnt_next = '0;
            if (req.num == '0)
            begin
                quo_next  = '0;
                done_next = 1'b1;
            end
            else if (req.den == '0)
            begin
                quo_next  = nddi_pkg::from_mag(nddi_pkg::MAG_MAX, req.num[63]);
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            nm_next  = {nm_reg[62:0], 1'b0};
            ovf_next = ovf_reg | (|q_reg[63:62]);
            q_next   = {q_reg[62:0], ge};
            rem_next = ge ? rem_diff[32:0] : rem_sh[32:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(STEPS - 1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            fin_next  = 1'b0;
            quo_next  = nddi_pkg::from_mag(ovf_reg ? nddi_pkg::MAG_MAX : q_reg, neg_reg);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nm_reg  <= nm_next;
        dm_reg  <= dm_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== design/nddi_mul.sv =====
// ============================================================================
// nddi_mul: sequential saturating multiplier
// 64 by 64 bit sign/magnitude product from four 32 by 32 partial products,
// shifted right by FRAC_BITS or by twice that, truncated and saturated.
// ============================================================================
module nddi_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  nddi_pkg::mul_req_t  req,
    output logic                done,
    output logic signed [63:0]  res
);

    localparam int SH0 = nddi_pkg::FRAC_BITS;
    localparam int SH1 = nddi_pkg::IFRAC;

    logic               busy_reg, busy_next;
    logic               fin_reg, fin_next;
    logic               done_reg, done_next;
    logic [63:0]        xm_reg, xm_next;
    logic [63:0]        ym_reg, ym_next;
    logic               neg_reg, neg_next;
    logic               wide_reg, wide_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic [127:0]       acc_reg, acc_next;
    logic signed [63:0] res_reg, res_next;
    logic [31:0]        xs, ys;
    logic [63:0]        pp;
    logic [6:0]         pp_sh;
    logic               ovf;
    logic [63:0]        r;

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = fin_reg;
        done_next = 1'b0;
        xm_next   = xm_reg;
        ym_next   = ym_reg;
        neg_next  = neg_reg;
        wide_next = wide_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        res_next  = res_reg;
        xs        = cnt_reg[0] ? xm_reg[63:32] : xm_reg[31:0];
        ys        = cnt_reg[1] ? ym_reg[63:32] : ym_reg[31:0];
        pp        = 64'(xs) * 64'(ys);
        pp_sh     = {(2'(cnt_reg[0]) + 2'(cnt_reg[1])), 5'd0};
        if (wide_reg)
        begin
            ovf = |acc_reg[127:64+SH1];
            r   = acc_reg[63+SH1:SH1];
        end
        else
        begin
            ovf = |acc_reg[127:64+SH0];
            r   = acc_reg[63+SH0:SH0];
        end
        if (req.start)
        begin
            xm_next   = nddi_pkg::mag64(req.a);
            ym_next   = nddi_pkg::mag64(req.b);
            neg_next  = req.a[63] ^ req.b[63];
            wide_next = req.wide;
            cnt_next  = '0;
            acc_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + (128'(pp) << pp_sh);
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 2'd3)
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            fin_next  = 1'b0;
            res_next  = nddi_pkg::from_mag(ovf ? nddi_pkg::MAG_MAX : r, neg_reg);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xm_reg   <= xm_next;
        ym_reg   <= ym_next;
        neg_reg  <= neg_next;
        wide_reg <= wide_next;
        cnt_reg  <= cnt_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ===== design/newton_divided_difference_interp_top.sv =====
// ============================================================================
// newton_divided_difference_interp_top: Newton divided-difference interpolator
// Node table and divided-difference table in synchronous memories, driven by
// a sequencer with a shared serial divider and a sequential multiplier.
// ============================================================================
// Usage:
//   Requests arrive on req_valid/req_ready/req; one response per request leaves
//   on rsp_valid/rsp_ready/rsp. A load request (command 0) stores one node and
//   answers with status load accepted or rejected. An evaluate request (command 1)
//   works over at most min(node_count, MAX_NODES)-1 steps, none when node_count is
//   0 or 1; each divided difference takes a pass of the bit-serial divider (skipped
//   when its numerator or abscissa difference is zero) and each step two passes of
//   the four-product multiplier.
//   One request is worked on at a time; req_ready is high while the sequencer
//   is idle, including while a finished response waits in the output register.
//   If the receiver stalls, the next response is held until the register frees.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
//   belong in idle periods. Reset clears the written marks of all node slots
//   and sets tolerance to 655 and node_count to 1; memory contents are kept.
// ============================================================================
`include "assert_macros.svh"

module newton_divided_difference_interp_top #(
    parameter int MAX_NODES = nddi_pkg::MAX_NODES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  nddi_pkg::req_t                    req,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output nddi_pkg::rsp_t                    rsp,
    input  logic                              cfg_we,
    input  logic [nddi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nddi_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int F  = nddi_pkg::FRAC_BITS;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LD     = 4'd1;
    localparam logic [3:0] S_E_INIT = 4'd2;
    localparam logic [3:0] S_E_K    = 4'd3;
    localparam logic [3:0] S_E_RD   = 4'd4;
    localparam logic [3:0] S_E_DIV  = 4'd5;
    localparam logic [3:0] S_E_M1   = 4'd6;
    localparam logic [3:0] S_E_M2   = 4'd7;
    localparam logic [3:0] S_E_CHK  = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0]           state_reg, state_next;
    nddi_pkg::req_t       cmd_reg, cmd_next;
    logic [AW-1:0]        k_reg, k_next;
    logic [AW-1:0]        i_reg, i_next;
    logic [AW-1:0]        nm1_reg, nm1_next;
    logic signed [31:0]   xk1_reg, xk1_next;
    logic signed [31:0]   axk_reg, axk_next;
    logic signed [63:0]   cur_reg, cur_next;
    logic signed [63:0]   p_reg, p_next;
    logic signed [63:0]   m_reg, m_next;
    logic                 small_reg, small_next;
    nddi_pkg::rsp_t       res_reg, res_next;
    nddi_pkg::rsp_t       out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;
    logic [MAX_NODES-1:0] written_reg, written_next;
    logic [30:0]          tolerance_reg;
    logic [4:0]           node_count_reg;

    nddi_pkg::node_t      node_mem [MAX_NODES];
    nddi_pkg::node_t      node_rd_reg;
    logic [AW-1:0]        node_raddr;
    logic                 node_we;
    logic [AW-1:0]        node_waddr;
    nddi_pkg::node_t      node_wdata;

    logic signed [63:0]   diff_mem [MAX_NODES];
    logic signed [63:0]   diff_rd_reg;
    logic [AW-1:0]        diff_raddr;
    logic                 diff_we;
    logic [AW-1:0]        diff_waddr;
    logic signed [63:0]   diff_wdata;

    nddi_pkg::div_req_t   div_req;
    logic                 div_done;
    logic signed [63:0]   div_quo;
    nddi_pkg::mul_req_t   mul_req;
    logic                 mul_done;
    logic signed [63:0]   mul_res;

    logic                 req_fire;
    logic                 in_range;
    logic [AW-1:0]        ld_addr;
    logic [AW-1:0]        prev_addr;
    logic                 ld_ok;
    logic signed [63:0]   p_new;
    logic [63:0]          pm;
    logic [63-F:0]        rq;
    logic                 neg_big;
    logic                 pos_big;
    logic signed [31:0]   conv_value;
    logic signed [32:0]   qdiff;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;

    assign in_range  = 32'(cmd_reg.node_index) < MAX_NODES;
    assign ld_addr   = AW'(cmd_reg.node_index);
    assign prev_addr = ld_addr - AW'(1);
    assign ld_ok     = in_range && ((cmd_reg.node_index == 4'd0) ||
                       (written_reg[prev_addr] && (cmd_reg.node_x > node_rd_reg.x)));

    assign p_new   = nddi_pkg::sat_add(p_reg, mul_res);
    assign pm      = nddi_pkg::mag64(p_reg);
    assign rq      = pm[63:F];
    assign neg_big = (|rq[63-F:32]) || (rq[31] && (|rq[30:0]));
    assign pos_big = |rq[63-F:31];
    assign qdiff   = $signed({cmd_reg.query_x[31], cmd_reg.query_x}) -
                     $signed({axk_reg[31], axk_reg});

    always_comb
    begin
        if (!p_reg[63])
            conv_value = pos_big ? 32'sh7FFF_FFFF : $signed(rq[31:0]);
        else if (neg_big)
            conv_value = 32'sh8000_0000;
        else
            conv_value = -$signed(rq[31:0]);
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        nm1_next     = nm1_reg;
        xk1_next     = xk1_reg;
        axk_next     = axk_reg;
        cur_next     = cur_reg;
        p_next       = p_reg;
        m_next       = m_reg;
        small_next   = small_reg;
        res_next     = res_reg;
        written_next = written_reg;
        node_raddr   = '0;
        node_we      = 1'b0;
        node_waddr   = ld_addr;
        node_wdata   = '{x: cmd_reg.node_x, y: cmd_reg.node_y};
        diff_raddr   = i_reg;
        diff_we      = 1'b0;
        diff_waddr   = i_reg;
        diff_wdata   = cur_reg;
        div_req      = '{start: 1'b0, num: nddi_pkg::sat_sub(cur_reg, diff_rd_reg),
                         den: $signed({xk1_reg[31], xk1_reg}) -
                              $signed({node_rd_reg.x[31], node_rd_reg.x})};
        mul_req      = '{start: 1'b0, wide: 1'b0, a: m_reg, b: 64'(qdiff)};

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    cmd_next = req;
                    if (req.command == nddi_pkg::CMD_LOAD)
                    begin
                        node_raddr = AW'(req.node_index) - AW'(1);
                        state_next = S_LD;
                    end
                    else
                    begin
                        node_raddr = '0;
                        if (node_count_reg == 5'd0)
                            nm1_next = '0;
                        else if (32'(node_count_reg) > MAX_NODES)
                            nm1_next = AW'(MAX_NODES - 1);
                        else
                            nm1_next = AW'(node_count_reg - 5'd1);
                        state_next = S_E_INIT;
                    end
                end
            end
            S_LD:
            begin
                if (ld_ok)
                begin
                    node_we = 1'b1;
                    for (int j = 0; j < MAX_NODES; j++)
                    begin
                        if (j == 32'(cmd_reg.node_index))
                            written_next[j] = 1'b1;
                        else if (j > 32'(cmd_reg.node_index))
                            written_next[j] = 1'b0;
                    end
                end
                res_next   = '{value: '0,
                               status: ld_ok ? nddi_pkg::ST_LOAD_OK : nddi_pkg::ST_LOAD_REJ};
                state_next = S_OUT;
            end
            S_E_INIT:
            begin
                p_next     = {{32{node_rd_reg.y[31]}}, node_rd_reg.y} << F;
                diff_we    = 1'b1;
                diff_waddr = '0;
                diff_wdata = {{32{node_rd_reg.y[31]}}, node_rd_reg.y} << F;
                m_next     = 64'sd1 << nddi_pkg::IFRAC;
                if (nm1_reg == '0)
                begin
                    res_next   = '{value: 32'sh7FFF_FFFF, status: nddi_pkg::ST_NO_CONV};
                    state_next = S_OUT;
                end
                else
                begin
                    k_next     = '0;
                    node_raddr = AW'(1);
                    state_next = S_E_K;
                end
            end
            S_E_K:
            begin
                xk1_next   = node_rd_reg.x;
                cur_next   = {{32{node_rd_reg.y[31]}}, node_rd_reg.y} << F;
                diff_we    = 1'b1;
                diff_waddr = k_reg + AW'(1);
                diff_wdata = {{32{node_rd_reg.y[31]}}, node_rd_reg.y} << F;
                i_next     = k_reg;
                node_raddr = k_reg;
                diff_raddr = k_reg;
                state_next = S_E_RD;
            end
            S_E_RD:
            begin
                if (i_reg == k_reg)
                    axk_next = node_rd_reg.x;
                div_req.start = 1'b1;
                state_next    = S_E_DIV;
            end
            S_E_DIV:
            begin
                if (div_done)
                begin
                    cur_next   = div_quo;
                    diff_we    = 1'b1;
                    diff_waddr = i_reg;
                    diff_wdata = div_quo;
                    if (i_reg == '0)
                    begin
                        mul_req.start = 1'b1;
                        state_next    = S_E_M1;
                    end
                    else
                    begin
                        i_next     = i_reg - AW'(1);
                        node_raddr = i_reg - AW'(1);
                        diff_raddr = i_reg - AW'(1);
                        state_next = S_E_RD;
                    end
                end
            end
            S_E_M1:
            begin
                if (mul_done)
                begin
                    m_next     = mul_res;
                    mul_req    = '{start: 1'b1, wide: 1'b1, a: cur_reg, b: mul_res};
                    state_next = S_E_M2;
                end
            end
            S_E_M2:
            begin
                if (mul_done)
                begin
                    p_next     = p_new;
                    small_next = nddi_pkg::mag64(mul_res) < (64'(tolerance_reg) << F);
                    state_next = S_E_CHK;
                end
            end
            S_E_CHK:
            begin
                if (small_reg)
                begin
                    res_next   = '{value: conv_value, status: nddi_pkg::ST_CONVERGED};
                    state_next = S_OUT;
                end
                else if (k_reg + AW'(1) == nm1_reg)
                begin
                    res_next   = '{value: 32'sh7FFF_FFFF, status: nddi_pkg::ST_NO_CONV};
                    state_next = S_OUT;
                end
                else
                begin
                    k_next     = k_reg + AW'(1);
                    node_raddr = k_reg + AW'(2);
                    state_next = S_E_K;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || rsp_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (rsp_ready)
            out_valid_next = 1'b0;
        if ((state_reg == S_OUT) && (!out_valid_reg || rsp_ready))
        begin
            out_next       = res_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            written_reg    <= '0;
            tolerance_reg  <= nddi_pkg::TOLERANCE_RESET;
            node_count_reg <= nddi_pkg::NODE_COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            written_reg   <= written_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    nddi_pkg::REG_TOLERANCE:  tolerance_reg  <= cfg_data[30:0];
                    nddi_pkg::REG_NODE_COUNT: node_count_reg <= cfg_data[4:0];
                    default:                  tolerance_reg  <= tolerance_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        k_reg     <= k_next;
        i_reg     <= i_next;
        nm1_reg   <= nm1_next;
        xk1_reg   <= xk1_next;
        axk_reg   <= axk_next;
        cur_reg   <= cur_next;
        p_reg     <= p_next;
        m_reg     <= m_next;
        small_reg <= small_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
            node_mem[node_waddr] <= node_wdata;
        node_rd_reg <= node_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (diff_we)
            diff_mem[diff_waddr] <= diff_wdata;
        diff_rd_reg <= diff_mem[diff_raddr];
    end

    nddi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quo   (div_quo)
    );

    nddi_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .done  (mul_done),
        .res   (mul_res)
    );

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `ASSERT_NEXT(a_load_to_check, clk, rst_n, req_fire && (req.command == nddi_pkg::CMD_LOAD), state_reg == S_LD)
    `ASSERT_IMPLIES(a_div_done_state, clk, rst_n, div_done, state_reg == S_E_DIV)
    `ASSERT_IMPLIES(a_mul_done_state, clk, rst_n, mul_done, (state_reg == S_E_M1) || (state_reg == S_E_M2))
    `ASSERT_IMPLIES(a_rsp_from_out, clk, rst_n, $rose(out_valid_reg), $past(state_reg == S_OUT))

endmodule

// ===== tb/tb_top.sv =====
// ============================================================================
// tb_top: self-checking bench for the Newton divided-difference interpolator
// Drives load and evaluate requests with random gaps on both handshakes,
// predicts every response from a local copy of the node table and registers,
// and compares each response field by field in arrival order.
// ============================================================================
module tb_top;

    logic                            clk;
    logic                            rst_n;
    logic                            req_valid;
    logic                            req_ready;
    nddi_pkg::req_t                  req;
    logic                            rsp_valid;
    logic                            rsp_ready;
    nddi_pkg::rsp_t                  rsp;
    logic                            cfg_we;
    logic [nddi_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [nddi_pkg::CFG_DATA_W-1:0] cfg_data;

    newton_divided_difference_interp_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // local image of the block
    logic signed [31:0] node_x_img [nddi_pkg::MAX_NODES];
    logic signed [31:0] node_y_img [nddi_pkg::MAX_NODES];
    bit                 slot_loaded [nddi_pkg::MAX_NODES];
    logic [30:0]        tolerance_img;
    logic [4:0]         count_img;

    nddi_pkg::rsp_t expected_rsp [$];

    bit no_idle;
    int hold_cycles;
    int mismatches;
    int requests_sent;
    int loads_ok, loads_rej, evals_conv, evals_noconv;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #200_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------- prediction arithmetic ----------------
    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] signed_clip(input logic [127:0] m, input bit neg);
        logic [63:0] c;
        c = (m > 128'(nddi_pkg::MAG_MAX)) ? nddi_pkg::MAG_MAX : m[63:0];
        return neg ? -$signed(c) : $signed(c);
    endfunction

    function automatic logic signed [63:0] clip65(input logic signed [64:0] s);
        if (s > $signed({1'b0, nddi_pkg::MAG_MAX}))
            return $signed(nddi_pkg::MAG_MAX);
        if (s < -$signed({1'b0, nddi_pkg::MAG_MAX}))
            return -$signed(nddi_pkg::MAG_MAX);
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sum_clip(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        return clip65($signed({a[63], a}) + $signed({b[63], b}));
    endfunction

    function automatic logic signed [63:0] diff_clip(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        return clip65($signed({a[63], a}) - $signed({b[63], b}));
    endfunction

    function automatic logic signed [63:0] product_shift(input logic signed [63:0] a,
                                                         input logic signed [63:0] b,
                                                         input int sh);
        logic [127:0] p;
        p = {64'b0, magnitude(a)} * {64'b0, magnitude(b)};
        return signed_clip(p >> sh, a[63] ^ b[63]);
    endfunction

    function automatic logic signed [63:0] quotient_frac(input logic signed [63:0] num,
                                                         input logic signed [63:0] den);
        logic [127:0] q;
        if (num == 0)
            return '0;
        if (den == 0)
            return signed_clip(128'(nddi_pkg::MAG_MAX), num[63]);
        q = ({64'b0, magnitude(num)} << nddi_pkg::FRAC_BITS) / {64'b0, magnitude(den)};
        return signed_clip(q, num[63] ^ den[63]);
    endfunction

    function automatic logic signed [63:0] widen(input logic signed [31:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        return w <<< nddi_pkg::FRAC_BITS;
    endfunction

    function automatic int active_nodes();
        if (count_img == 0)
            return 1;
        if (int'(count_img) > nddi_pkg::MAX_NODES)
            return nddi_pkg::MAX_NODES;
        return int'(count_img);
    endfunction

    function automatic bit nodes_ready(input int n);
        for (int i = 0; i < n; i++)
            if (!slot_loaded[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // updates the image on loads and returns the response owed to r
    function automatic nddi_pkg::rsp_t interpolate(input nddi_pkg::req_t r);
        nddi_pkg::rsp_t     o;
        int                 idx;
        int                 n;
        bit                 ok;
        logic signed [63:0] tbl [nddi_pkg::MAX_NODES];
        logic signed [63:0] qx, mterm, acc, delta, den;
        logic [63:0]        mg, tol64;
        o.value = '0;
        if (r.command == nddi_pkg::CMD_LOAD)
        begin
            idx = int'(r.node_index);
            ok = (idx < nddi_pkg::MAX_NODES) && ((idx == 0) ||
                 (slot_loaded[idx-1] && (r.node_x > node_x_img[idx-1])));
            if (ok)
            begin
                node_x_img[idx] = r.node_x;
                node_y_img[idx] = r.node_y;
                slot_loaded[idx] = 1'b1;
                for (int j = idx + 1; j < nddi_pkg::MAX_NODES; j++)
                    slot_loaded[j] = 1'b0;
            end
            o.status = ok ? nddi_pkg::ST_LOAD_OK : nddi_pkg::ST_LOAD_REJ;
            return o;
        end
        n = active_nodes();
        qx = 64'(r.query_x);
        tol64 = 64'(tolerance_img) << nddi_pkg::FRAC_BITS;
        mterm = 64'sh1_0000_0000;
        tbl[0] = widen(node_y_img[0]);
        acc = tbl[0];
        for (int k = 0; k < n - 1; k++)
        begin
            tbl[k+1] = widen(node_y_img[k+1]);
            for (int i = k; i >= 0; i--)
            begin
                den = 64'(node_x_img[k+1]) - 64'(node_x_img[i]);
                tbl[i] = quotient_frac(diff_clip(tbl[i+1], tbl[i]), den);
            end
            mterm = product_shift(mterm, qx - 64'(node_x_img[k]), nddi_pkg::FRAC_BITS);
            delta = product_shift(tbl[0], mterm, nddi_pkg::IFRAC);
            acc = sum_clip(acc, delta);
            if (magnitude(delta) < tol64)
            begin
                mg = magnitude(acc) >> nddi_pkg::FRAC_BITS;
                if (acc < 0)
                    o.value = (mg > 64'h8000_0000) ? 32'h8000_0000 : -mg[31:0];
                else
                    o.value = (mg > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mg[31:0];
                o.status = nddi_pkg::ST_CONVERGED;
                return o;
            end
        end
        o.value = 32'h7FFF_FFFF;
        o.status = nddi_pkg::ST_NO_CONV;
        return o;
    endfunction

    // ---------------- drivers ----------------
    function automatic nddi_pkg::req_t load_req(input int idx, input logic [31:0] x,
                                                input logic [31:0] y);
        nddi_pkg::req_t r;
        r.command = nddi_pkg::CMD_LOAD;
        r.node_index = 4'(idx);
        r.node_x = x;
        r.node_y = y;
        r.query_x = $urandom;
        return r;
    endfunction

    function automatic nddi_pkg::req_t eval_req(input logic [31:0] q);
        nddi_pkg::req_t r;
        r.command = nddi_pkg::CMD_EVAL;
        r.node_index = 4'($urandom_range(0, 15));
        r.node_x = $urandom;
        r.node_y = $urandom;
        r.query_x = q;
        return r;
    endfunction

    task automatic send_req(input nddi_pkg::req_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do @(posedge clk); while (!req_ready);
        expected_rsp.push_back(interpolate(r));
        requests_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        req_valid <= 1'b0;
        wait (expected_rsp.size() == 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [nddi_pkg::CFG_IDX_W-1:0] idx,
                             input logic [30:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == nddi_pkg::REG_TOLERANCE)
            tolerance_img = data;
        else
            count_img = data[4:0];
    endtask

    // ---------------- response side ----------------
    initial
    begin : receiver
        int gap;
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            gap = hold_cycles > 0 ? hold_cycles : (no_idle ? 0 : $urandom_range(0, 5));
            hold_cycles = 0;
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    always @(posedge clk)
    begin
        nddi_pkg::rsp_t e;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response value=%h status=%0d",
                             rsp.value, rsp.status);
            end
            else
            begin
                e = expected_rsp.pop_front();
                if (rsp.value !== e.value || rsp.status !== e.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                                 e.value, e.status, rsp.value, rsp.status);
                end
                case (e.status)
                    nddi_pkg::ST_CONVERGED: evals_conv++;
                    nddi_pkg::ST_NO_CONV:   evals_noconv++;
                    nddi_pkg::ST_LOAD_OK:   loads_ok++;
                    default:                loads_rej++;
                endcase
            end
        end
    end

    // ---------------- tests ----------------
    task automatic test_load_order();
        send_req(load_req(1, 32'h0000_1000, 32'h0000_0001));
        send_req(load_req(0, 32'h8000_0000, 32'h7FFF_FFFF));
        send_req(load_req(1, 32'h8000_0000, 32'h0000_0005));
        send_req(load_req(1, 32'h7FFF_FFFF, 32'h8000_0000));
        send_req(load_req(2, 32'h0000_0000, 32'h0000_0000));
        send_req(load_req(15, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        wait_idle();
    endtask

    task automatic test_single_node();
        write_reg(nddi_pkg::REG_NODE_COUNT, 31'd0);
        send_req(eval_req(32'h0001_0000));
        wait_idle();
        write_reg(nddi_pkg::REG_NODE_COUNT, 31'd1);
        send_req(eval_req(32'h8000_0000));
        wait_idle();
    endtask

    task automatic test_extremes();
        write_reg(nddi_pkg::REG_NODE_COUNT, 31'd2);
        send_req(eval_req(32'h8000_0000));
        send_req(eval_req(32'h7FFF_FFFF));
        wait_idle();
        write_reg(nddi_pkg::REG_TOLERANCE, 31'd0);
        send_req(eval_req(32'h0000_0000));
        wait_idle();
        write_reg(nddi_pkg::REG_TOLERANCE, 31'h7FFF_FFFF);
        send_req(eval_req(32'hFFFF_0000));
        wait_idle();
    endtask

    task automatic test_linear_data();
        write_reg(nddi_pkg::REG_TOLERANCE, 31'd655);
        write_reg(nddi_pkg::REG_NODE_COUNT, 31'd4);
        for (int i = 0; i < 4; i++)
            send_req(load_req(i, 32'(i) << 16, 32'(2 * i + 1) << 16));
        send_req(eval_req(32'h0001_8000));
        wait_idle();
    endtask

    task automatic test_backpressure();
        no_idle = 1'b1;
        hold_cycles = 300;
        for (int i = 0; i < 20; i++)
            send_req(load_req(i % 16, $urandom, $urandom));
        wait_idle();
        no_idle = 1'b0;
    endtask

    task automatic load_node_set(input int n, input bit smooth);
        longint x0, stp, xi, a, b, c;
        if (smooth)
        begin
            x0 = $signed($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            stp = $urandom_range(32'h4000, 32'h4_0000);
            a = $signed($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            b = $signed($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
            c = $signed($urandom_range(0, 32'h0000_8000)) - 32'h0000_4000;
            for (int i = 0; i < n; i++)
                send_req(load_req(i, 32'(x0 + i * stp), 32'(a + b * i + c * i * i)));
        end
        else
        begin
            xi = -(longint'(1) << 31) + $urandom_range(0, 32'h0010_0000);
            stp = ((longint'(1) << 32) - (longint'(1) << 21)) / n;
            for (int i = 0; i < n; i++)
            begin
                if (i > 0)
                    xi = xi + $urandom_range(1, 32'(stp));
                send_req(load_req(i, 32'(xi), $urandom));
            end
        end
    endtask

    task automatic test_random(input int total);
        int  n, sel, evals;
        bit  smooth;
        logic [31:0] q;
        while (requests_sent < total)
        begin
            no_idle = ($urandom_range(0, 5) == 0);
            sel = $urandom_range(0, 9);
            write_reg(nddi_pkg::REG_TOLERANCE, sel == 0 ? 31'd0 : sel == 1 ? 31'h7FFF_FFFF :
                      sel < 6 ? 31'($urandom_range(1, 4000)) : 31'($urandom));
            sel = $urandom_range(0, 99);
            write_reg(nddi_pkg::REG_NODE_COUNT, sel < 2 ? 31'd0 : sel < 7 ? 31'd1 :
                      sel < 77 ? 31'($urandom_range(2, 4)) :
                      sel < 96 ? 31'($urandom_range(5, 8)) :
                      sel < 98 ? 31'd16 : 31'($urandom_range(17, 31)));
            n = active_nodes();
            smooth = $urandom_range(0, 3) != 0;
            if (!nodes_ready(n) || $urandom_range(0, 2) != 0)
                load_node_set(n, smooth);
            evals = n > 8 ? 2 : $urandom_range(4, 10);
            for (int e = 0; e < evals; e++)
            begin
                if ($urandom_range(0, 3) == 0)
                    q = $urandom;
                else
                    q = node_x_img[0] + $urandom_range(0, 32'h0008_0000) - 32'h0001_0000;
                send_req(eval_req(q));
            end
            repeat ($urandom_range(0, 3))
                send_req(load_req($urandom_range(0, 15), $urandom, $urandom));
            wait_idle();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        no_idle = 1'b0;
        hold_cycles = 0;
        tolerance_img = nddi_pkg::TOLERANCE_RESET;
        count_img = nddi_pkg::NODE_COUNT_RESET;
        for (int i = 0; i < nddi_pkg::MAX_NODES; i++)
        begin
            slot_loaded[i] = 1'b0;
            node_x_img[i] = '0;
            node_y_img[i] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_load_order();
        test_single_node();
        test_extremes();
        test_linear_data();
        test_backpressure();
        test_random(1250);
        wait_idle();

        $display("covered %0d requests: %0d loads taken, %0d loads refused",
                 requests_sent, loads_ok, loads_rej);
        $display("evaluations: %0d converged, %0d without convergence; %0d mismatches",
                 evals_conv, evals_noconv, mismatches);
        if (mismatches == 0 && expected_rsp.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
